[hw/rtl/ryuv_pkg.sv]
// Shared types and constants for the RGB to planar YUV 4:2:0 converter.
`default_nettype none
package ryuv_pkg;

	// Configuration register width and index codes
	localparam int CFG_W   = 13;
	localparam int CIDX_W  = 1;
	localparam logic [CIDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CIDX_W-1:0] REG_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1920;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd1080;

	// Internal widths
	localparam int DIM_W   = CFG_W + 1;   // effective dimension, holds 8192
	localparam int LADDR_W = 24;
	localparam int CADDR_W = 22;
	localparam int OFS_W   = 25;
	localparam int SUM_W   = 17;

	// Plane codes
	localparam logic [1:0] PLANE_Y = 2'd0;
	localparam logic [1:0] PLANE_U = 2'd1;
	localparam logic [1:0] PLANE_V = 2'd2;

	// Input word
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// Result word
	typedef struct packed {
		logic [1:0]       plane;
		logic [OFS_W-1:0] byte_offset;
		logic [7:0]       sample_value;
		logic             last_of_pixel;
		logic             end_of_frame;
	} result_t;

	// Classified pixel handed from front to back
	typedef struct packed {
		pixel_t             pix;
		logic [LADDR_W-1:0] luma_addr;
		logic [CADDR_W-1:0] chroma_addr;
		logic               is_chroma;
		logic               frame_end;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
	} cmd_t;

endpackage
`default_nettype wire

[hw/rtl/rgb_to_yuv420_planar.sv]
// Top level of the streaming RGB24 to I420 (BT.601 studio range) converter.
// Pixels enter in raster order, one per cycle while full is low; each yields a
// luma word, and pixels on even rows and even columns also yield U and V words,
// each tagged with its plane and byte offset in one I420 frame buffer. Results
// leave through a single result port at one word per cycle while the consumer
// pops, so a pixel takes one word of that port, or three on chroma sites. A
// pixel passes through the command queue, two arithmetic stages and then the
// result queue before its first result reaches the result ports.
// Counters wrap to the frame start after the last pixel of each frame.
`default_nettype none
module rgb_to_yuv420_planar #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ryuv_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [ryuv_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        push,
	output logic                             full,
	input  wire ryuv_pkg::pixel_t            pixel,
	output logic                             empty,
	input  wire logic                        pop,
	output ryuv_pkg::result_t                result
);
	localparam int CMD_W = $bits(ryuv_pkg::cmd_t);
	localparam int RES_W = $bits(ryuv_pkg::result_t);

	ryuv_pkg::cmd_t    cmd_in, cmd_out;
	ryuv_pkg::result_t res_in;
	logic              accept, cmd_empty, cmd_pop, res_push, res_full;

	assign accept = push && !full;

	// Front: classify accepted pixels
	ryuv_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.pixel    (pixel),
		.cmd      (cmd_in)
	);

	// Queue between front and back
	ryuv_fifo #(
		.DATA_W(CMD_W),
		.DEPTH (4)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (push),
		.wdata (cmd_in),
		.full  (full),
		.rd_en (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	// Back: conversion and serialization
	ryuv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_out),
		.cmd_valid(!cmd_empty),
		.cmd_pop  (cmd_pop),
		.result   (res_in),
		.res_push (res_push),
		.res_full (res_full)
	);

	// Result queue facing the consumer
	ryuv_fifo #(
		.DATA_W(RES_W),
		.DEPTH (4)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (res_push),
		.wdata (res_in),
		.full  (res_full),
		.rd_en (pop),
		.rdata (result),
		.empty (empty)
	);
endmodule
`default_nettype wire

[hw/rtl/ryuv_fifo.sv]
// Small register-based first-in first-out queue.
`default_nettype none
module ryuv_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [DATA_W-1:0] wdata,
	output logic                   full,
	input  wire logic              rd_en,
	output logic [DATA_W-1:0]      rdata,
	output logic                   empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]     count_q;
	logic              do_wr, do_rd;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/ryuv_front.sv]
// Front end: configuration registers, raster counters and pixel classification.
`default_nettype none
module ryuv_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [ryuv_pkg::CIDX_W-1:0]         cfg_index,
	input  wire logic [ryuv_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                accept,
	input  wire ryuv_pkg::pixel_t                    pixel,
	output ryuv_pkg::cmd_t                           cmd
);
	localparam int DW = ryuv_pkg::DIM_W;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [DW-1:0] MAXW_EVEN = DW'(MAX_WIDTH - (MAX_WIDTH % 2));
	localparam logic [DW-1:0] MAXH      = DW'(MAX_HEIGHT);

	logic [ryuv_pkg::CFG_W-1:0]   width_q, height_q;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [ryuv_pkg::LADDR_W-1:0] laddr_q;
	logic [ryuv_pkg::CADDR_W-1:0] caddr_q;
	logic [DW-1:0]                w_raw, h_raw, w_eff, h_eff;
	logic                         row_end, frame_end, is_chroma;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ryuv_pkg::WIDTH_RST;
			height_q <= ryuv_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ryuv_pkg::REG_WIDTH:  width_q  <= cfg_data;
				ryuv_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective frame size: even width, both clamped to their range
	always_comb begin
		w_raw = {1'b0, width_q[ryuv_pkg::CFG_W-1:1], 1'b0};
		h_raw = {1'b0, height_q};
		if (w_raw > MAXW_EVEN) begin
			w_eff = MAXW_EVEN;
		end else if (w_raw < DW'(2)) begin
			w_eff = DW'(2);
		end else begin
			w_eff = w_raw;
		end
		if (h_raw > MAXH) begin
			h_eff = MAXH;
		end else if (h_raw == '0) begin
			h_eff = DW'(1);
		end else begin
			h_eff = h_raw;
		end
	end

	// Classify the pixel at the current raster position
	assign row_end   = (DW'(col_q) + DW'(1)) >= w_eff;
	assign frame_end = row_end && ((DW'(row_q) + DW'(1)) >= h_eff);
	assign is_chroma = !row_q[0] && !col_q[0];

	always_comb begin
		cmd.pix         = pixel;
		cmd.luma_addr   = laddr_q;
		cmd.chroma_addr = caddr_q;
		cmd.is_chroma   = is_chroma;
		cmd.frame_end   = frame_end;
		cmd.width       = w_eff;
		cmd.height      = h_eff;
	end

	// Raster counters and plane addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			laddr_q <= '0;
			caddr_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				laddr_q <= '0;
				caddr_q <= '0;
			end else begin
				laddr_q <= laddr_q + 1'b1;
				if (is_chroma) begin
					caddr_q <= caddr_q + 1'b1;
				end
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

[hw/rtl/ryuv_back.sv]
// Back end: color conversion, frame buffer offsets and result serialization.
`default_nettype none
module ryuv_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ryuv_pkg::cmd_t   cmd,
	input  wire logic             cmd_valid,
	output logic                  cmd_pop,
	output ryuv_pkg::result_t     result,
	output logic                  res_push,
	input  wire logic             res_full
);
	localparam int SW = ryuv_pkg::SUM_W;
	localparam int OW = ryuv_pkg::OFS_W;
	localparam int DW = ryuv_pkg::DIM_W;

	// Stage 1: weighted sums and plane sizes
	logic                         valid_s1;
	logic signed [SW-1:0]         ysum_s1, usum_s1, vsum_s1;
	logic [OW-1:0]                lsize_s1, csize_s1;
	logic [ryuv_pkg::LADDR_W-1:0] laddr_s1;
	logic [ryuv_pkg::CADDR_W-1:0] caddr_s1;
	logic                         chroma_s1, eof_s1;

	// Stage 2: finished samples and offsets, drained one word per cycle unless res_full
	logic                         valid_s2;
	logic [7:0]                   yval_s2, uval_s2, vval_s2;
	logic [OW-1:0]                yofs_s2, uofs_s2, vofs_s2;
	logic                         chroma_s2, eof_s2;
	logic [1:0]                   sel_q;

	logic signed [SW-1:0]         r_s, g_s, b_s;
	logic [2*DW-1:0]              lprod, cprod;
	logic [DW-1:0]                hp1;
	logic                         emit, done, free_s2, free_s1;

	assign r_s   = SW'($signed({1'b0, cmd.pix.red}));
	assign g_s   = SW'($signed({1'b0, cmd.pix.green}));
	assign b_s   = SW'($signed({1'b0, cmd.pix.blue}));
	assign hp1   = cmd.height + 1'b1;
	assign lprod = cmd.width * cmd.height;
	assign cprod = (cmd.width >> 1) * (hp1 >> 1);

	// Handshake between stages
	assign emit    = valid_s2 && !res_full;
	assign done    = emit && (!chroma_s2 || sel_q == 2'd2);
	assign free_s2 = !valid_s2 || done;
	assign free_s1 = !valid_s1 || free_s2;
	assign cmd_pop = cmd_valid && free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sel_q    <= 2'd0;
		end else begin
			if (free_s1) begin
				valid_s1 <= cmd_valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (done) begin
				sel_q <= 2'd0;
			end else if (emit) begin
				sel_q <= sel_q + 1'b1;
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (free_s1) begin
			ysum_s1   <= SW'(66) * r_s + SW'(129) * g_s + SW'(25) * b_s;
			usum_s1   <= SW'(112) * b_s - SW'(38) * r_s - SW'(74) * g_s;
			vsum_s1   <= SW'(112) * r_s - SW'(94) * g_s - SW'(18) * b_s;
			lsize_s1  <= lprod[OW-1:0];
			csize_s1  <= cprod[OW-1:0];
			laddr_s1  <= cmd.luma_addr;
			caddr_s1  <= cmd.chroma_addr;
			chroma_s1 <= cmd.is_chroma;
			eof_s1    <= cmd.frame_end;
		end
	end

	// Stage 2 payload: shift right by eight, add the offset, place in buffer
	always_ff @(posedge clk) begin
		if (free_s2) begin
			yval_s2   <= ysum_s1[15:8] + 8'd16;
			uval_s2   <= usum_s1[15:8] + 8'd128;
			vval_s2   <= vsum_s1[15:8] + 8'd128;
			yofs_s2   <= OW'(laddr_s1);
			uofs_s2   <= lsize_s1 + OW'(caddr_s1);
			vofs_s2   <= lsize_s1 + csize_s1 + OW'(caddr_s1);
			chroma_s2 <= chroma_s1;
			eof_s2    <= eof_s1;
		end
	end

	// Result word selection: Y, then U and V for chroma sites
	always_comb begin
		res_push             = emit;
		result.end_of_frame  = eof_s2;
		result.last_of_pixel = !chroma_s2 || sel_q == 2'd2;
		unique case (sel_q)
			2'd1: begin
				result.plane        = ryuv_pkg::PLANE_U;
				result.byte_offset  = uofs_s2;
				result.sample_value = uval_s2;
			end
			2'd2: begin
				result.plane        = ryuv_pkg::PLANE_V;
				result.byte_offset  = vofs_s2;
				result.sample_value = vval_s2;
			end
			default: begin
				result.plane        = ryuv_pkg::PLANE_Y;
				result.byte_offset  = yofs_s2;
				result.sample_value = yval_s2;
			end
		endcase
	end
endmodule
`default_nettype wire

[bench/rgb_to_yuv420_planar_tb.sv]
// Self-checking testbench for the RGB24 to I420 planar converter.
`default_nettype none
module rgb_to_yuv420_planar_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W     = 4096;
	localparam int MAX_H     = 4096;
	localparam int RUN_LIMIT = 200000;
	localparam int SETTLE    = 16;    // idle cycles after the expected words drain
	localparam int SHOWN     = 10;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [ryuv_pkg::CIDX_W-1:0]   cfg_index = ryuv_pkg::REG_WIDTH;
	logic [ryuv_pkg::CFG_W-1:0]    cfg_data  = '0;
	logic                          push      = 1'b0;
	logic                          full;
	ryuv_pkg::pixel_t              pixel     = '0;
	logic                          empty;
	logic                          pop       = 1'b0;
	ryuv_pkg::result_t             result;

	rgb_to_yuv420_planar i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5ns;
		clk = 1'b1;
		#5ns;
	end

	// Converter shadow: registers, raster counters and frame buffer addresses
	logic [ryuv_pkg::CFG_W-1:0]   shadow_width  = ryuv_pkg::WIDTH_RST;
	logic [ryuv_pkg::CFG_W-1:0]   shadow_height = ryuv_pkg::HEIGHT_RST;
	int unsigned                  col_pos       = 0;
	int unsigned                  row_pos       = 0;
	logic [ryuv_pkg::LADDR_W-1:0] luma_addr     = '0;
	logic [ryuv_pkg::CADDR_W-1:0] chroma_addr   = '0;

	ryuv_pkg::result_t expected_samples[$];

	int send_idle_pct  = 0;
	int pop_stall_pct  = 0;
	int pixels_sent    = 0;
	int words_checked  = 0;
	int frames_seen    = 0;
	int settings_used  = 0;
	int mismatch_count = 0;
	int cycle_count    = 0;

	// Work out the words one pixel yields and advance the raster position
	task automatic convert_pixel(input ryuv_pkg::pixel_t p);
		int unsigned w, h, luma_size, chroma_size;
		int r, g, b;
		bit row_end, frame_end, chroma_site;
		ryuv_pkg::result_t s;
		w = {shadow_width[ryuv_pkg::CFG_W-1:1], 1'b0};
		if (w > (MAX_W & ~1)) w = MAX_W & ~1;
		if (w < 2) w = 2;
		h = shadow_height;
		if (h > MAX_H) h = MAX_H;
		if (h < 1) h = 1;
		luma_size   = w * h;
		chroma_size = (w / 2) * ((h + 1) / 2);
		row_end     = (col_pos + 1 >= w);
		frame_end   = row_end && (row_pos + 1 >= h);
		chroma_site = !row_pos[0] && !col_pos[0];
		r = p.red;
		g = p.green;
		b = p.blue;

		s.plane         = ryuv_pkg::PLANE_Y;
		s.byte_offset   = ryuv_pkg::OFS_W'(luma_addr);
		s.sample_value  = 8'(((66 * r + 129 * g + 25 * b) >>> 8) + 16);
		s.last_of_pixel = !chroma_site;
		s.end_of_frame  = frame_end;
		expected_samples.push_back(s);
		if (chroma_site) begin
			s.plane         = ryuv_pkg::PLANE_U;
			s.byte_offset   = ryuv_pkg::OFS_W'(luma_size + chroma_addr);
			s.sample_value  = 8'(((-38 * r - 74 * g + 112 * b) >>> 8) + 128);
			s.last_of_pixel = 1'b0;
			expected_samples.push_back(s);
			s.plane         = ryuv_pkg::PLANE_V;
			s.byte_offset   = ryuv_pkg::OFS_W'(luma_size + chroma_size + chroma_addr);
			s.sample_value  = 8'(((112 * r - 94 * g - 18 * b) >>> 8) + 128);
			s.last_of_pixel = 1'b1;
			expected_samples.push_back(s);
			chroma_addr = chroma_addr + 1'b1;
		end
		luma_addr = luma_addr + 1'b1;

		// raster position; a row or frame ends once the count reaches the size
		if (frame_end) begin
			col_pos     = 0;
			row_pos     = 0;
			luma_addr   = '0;
			chroma_addr = '0;
		end else if (row_end) begin
			col_pos = 0;
			row_pos = row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	// Compare one popped word against the oldest expected one
	task automatic check_sample(input ryuv_pkg::result_t got);
		ryuv_pkg::result_t want;
		if (expected_samples.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= SHOWN)
				$display("[%0t] unexpected word: plane %0d ofs %0d val %0d last %0d eof %0d",
					$realtime, got.plane, got.byte_offset, got.sample_value,
					got.last_of_pixel, got.end_of_frame);
			return;
		end
		want = expected_samples.pop_front();
		words_checked++;
		if (got.plane !== want.plane || got.byte_offset !== want.byte_offset ||
				got.sample_value !== want.sample_value ||
				got.last_of_pixel !== want.last_of_pixel ||
				got.end_of_frame !== want.end_of_frame) begin
			mismatch_count++;
			if (mismatch_count <= SHOWN) begin
				$display("[%0t] word %0d expected: plane %0d ofs %0d val %0d last %0d eof %0d",
					$realtime, words_checked, want.plane, want.byte_offset,
					want.sample_value, want.last_of_pixel, want.end_of_frame);
				$display("[%0t] word %0d actual:   plane %0d ofs %0d val %0d last %0d eof %0d",
					$realtime, words_checked, got.plane, got.byte_offset,
					got.sample_value, got.last_of_pixel, got.end_of_frame);
			end
		end else if (got.end_of_frame && got.last_of_pixel) begin
			frames_seen++;
		end
	endtask

	// Result side: check accepted words, then decide whether to stall
	always @(posedge clk) begin
		if (pop && !empty)
			check_sample(result);
		pop <= (pop_stall_pct == 0) || ($urandom_range(99) >= pop_stall_pct);
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, expected_samples.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Push one pixel word, with random idle cycles ahead of it
	task automatic send_pixel(input ryuv_pkg::pixel_t p);
		int gap;
		gap = 0;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (full) @(posedge clk);
		convert_pixel(p);
		pixels_sent++;
	endtask

	// Hold off input until every expected word is out and the pipe is quiet
	task automatic drain_samples();
		push <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both dimension registers; only called with the converter idle
	task automatic set_dims(input logic [ryuv_pkg::CFG_W-1:0] w,
			input logic [ryuv_pkg::CFG_W-1:0] h);
		drain_samples();
		cfg_we    <= 1'b1;
		cfg_index <= ryuv_pkg::REG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		shadow_width = w;
		cfg_index <= ryuv_pkg::REG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		shadow_height = h;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic ryuv_pkg::pixel_t random_pixel();
		ryuv_pkg::pixel_t p;
		p = ryuv_pkg::pixel_t'($urandom);
		// bias some pixels toward saturated channels
		if ($urandom_range(7) == 0) begin
			p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
			p.green = $urandom_range(1) ? 8'hFF : 8'h00;
			p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
		end
		return p;
	endfunction

	// Primaries, secondaries, black and white at reset dimensions:
	// covers luma-only and chroma sites and both signs of the U chroma sum
	task automatic test_color_extremes();
		ryuv_pkg::pixel_t p;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		for (int k = 0; k < 8; k++) begin
			p.red   = k[0] ? 8'hFF : 8'h00;
			p.green = k[1] ? 8'hFF : 8'h00;
			p.blue  = k[2] ? 8'hFF : 8'h00;
			send_pixel(p);
		end
	endtask

	// Odd width with its low bit dropped and zero height: a 2x1 frame
	task automatic test_min_frames();
		set_dims(13'd3, 13'd0);
		for (int k = 0; k < 4; k++)
			send_pixel(random_pixel());
	endtask

	// Odd height: last chroma row must not run into the next plane
	task automatic test_odd_height();
		send_idle_pct = 31;
		pop_stall_pct = 31;
		set_dims(13'd2, 13'd3);
		for (int k = 0; k < 6; k++)
			send_pixel(random_pixel());
	endtask

	// Oversized and largest legal dimensions, then a shrink mid-frame
	task automatic test_dims_out_of_range();
		send_idle_pct = 0;
		pop_stall_pct = 0;
		set_dims(13'h1FFF, 13'h1FFF);
		for (int k = 0; k < 3; k++)
			send_pixel(random_pixel());
		set_dims(13'd4096, 13'd4096);
		for (int k = 0; k < 2; k++)
			send_pixel(random_pixel());
		// counters are past the new width, so the row and then the frame close
		set_dims(13'd1, 13'd2);
		for (int k = 0; k < 3; k++)
			send_pixel(random_pixel());
	endtask

	// Random pixels over random frame sizes, mostly small so frames complete
	task automatic test_random_stream(input int count, input int idle_pct,
			input int stall_pct);
		int left, burst, frame_px, w, h;
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		left = count;
		while (left > 0) begin
			if ($urandom_range(7) == 0) begin
				set_dims(ryuv_pkg::CFG_W'($urandom), ryuv_pkg::CFG_W'($urandom));
				burst = $urandom_range(1, 6);
			end else begin
				w = $urandom_range(9);
				h = $urandom_range(4);
				set_dims(ryuv_pkg::CFG_W'(w), ryuv_pkg::CFG_W'(h));
				w = (w < 2) ? 2 : (w & ~1);
				h = (h < 1) ? 1 : h;
				frame_px = w * h;
				burst = $urandom_range(1, frame_px + frame_px / 2);
			end
			if (burst > left) burst = left;
			for (int k = 0; k < burst; k++)
				send_pixel(random_pixel());
			left -= burst;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_color_extremes();
		test_min_frames();
		test_odd_height();
		test_dims_out_of_range();
		test_random_stream(32, 0, 0);
		test_random_stream(32, 53, 0);
		test_random_stream(32, 0, 53);
		test_random_stream(32, 31, 31);
		drain_samples();

		$display("Ran %0d pixels through %0d dimension settings, %0d frames closed.",
			pixels_sent, settings_used, frames_seen);
		$display("Checked %0d output words, %0d mismatches.", words_checked, mismatch_count);
		if (mismatch_count == 0 && expected_samples.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire
